// ===== hdl/sset_pkg.sv =====
// Shared types and constants for the sparse-set membership table.
// Holds command codes, widths and the sequencer state type.
// No dependencies.
package sset_pkg;

	// table depth and field widths
	localparam int MAX_IDS = 1024;
	localparam int IDX_W   = 10;
	localparam int CNT_W   = 11;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// map entry value that marks an untracked id
	localparam cnt_t INVALID_SLOT = cnt_t'(MAX_IDS);

	// command codes
	localparam logic [1:0] CMD_TRACK   = 2'd0;
	localparam logic [1:0] CMD_UNTRACK = 2'd1;
	localparam logic [1:0] CMD_QUERY   = 2'd2;

	// sequencer states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_UNLINK
	} state_t;

endpackage

// ===== hdl/sparse_set_membership_table.sv =====
// Sparse-set membership table: id-to-slot map, dense id list and count.
// Depends on sset_pkg and sset_ram.
//
//  channel  dir  signals                 word contents (low bit first)
//  s_axis   in   tvalid tready tdata     tdata: entity[9:0], zero fill to 16
//                tuser                   tuser: command[1:0]
//  m_axis   out  tvalid tready tdata     tdata: was_tracked, slot[10:0],
//                                               count[10:0], error
//
// Track, query and unused commands are accepted, then read and committed; an
// untrack that removes an id adds an unlink step, set by the single write port
// of the map RAM (two map writes). The result word is registered at commit.
// Each command first reads the map and the last dense entry, then commits.
// After reset a clearing pass writes every map entry invalid, with
// s_axis_tready low. A stalled result holds the next command in its
// read cycle until the output register frees up.
module sparse_set_membership_table
	import sset_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // entity[9:0], zeros
	input  logic [1:0]  s_axis_tuser,  // command[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // was_tracked, slot[10:0], count[10:0], error
);

	state_t state_q, state_d;

	logic [1:0] cmd_q;
	idx_t       ent_q;
	cnt_t       count_q;
	idx_t       clr_q;

	logic out_valid_q;
	logic out_was_q;
	cnt_t out_slot_q;
	cnt_t out_cnt_q;
	logic out_err_q;

	logic accept;
	logic out_free;
	logic commit;

	// map RAM ports
	logic smap_we;
	idx_t smap_waddr;
	cnt_t smap_wdata;
	idx_t smap_raddr;
	cnt_t smap_rdata;

	// dense list RAM ports
	logic dlst_we;
	idx_t dlst_waddr;
	idx_t dlst_wdata;
	idx_t dlst_raddr;
	idx_t dlst_rdata;

	// decode of the read results
	cnt_t cur;
	idx_t back;
	logic tracked;
	logic do_add;
	logic do_rem;
	logic is_track;
	cnt_t res_slot;
	cnt_t res_cnt;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign commit   = (state_q == ST_READ) && out_free;

	assign cur      = smap_rdata;
	assign back     = dlst_rdata;
	assign tracked  = cur < INVALID_SLOT;
	assign is_track = cmd_q == CMD_TRACK;
	assign do_add   = is_track && !tracked && (count_q < INVALID_SLOT);
	assign do_rem   = (cmd_q == CMD_UNTRACK) && tracked && (cur < count_q);

	// result of the committing command
	always_comb begin
		res_slot = cur;
		res_cnt  = count_q;
		if (do_add) begin
			res_slot = count_q;
			res_cnt  = count_q + cnt_t'(1);
		end else if (do_rem) begin
			res_slot = INVALID_SLOT;
			res_cnt  = count_q - cnt_t'(1);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == idx_t'(MAX_IDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (out_free) begin
					state_d = do_rem ? ST_UNLINK : ST_IDLE;
				end
			end
			ST_UNLINK: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// drive RAM controls from the state
	always_comb begin
		s_axis_tready = 1'b0;
		smap_we       = 1'b0;
		smap_waddr    = ent_q;
		smap_wdata    = INVALID_SLOT;
		dlst_we       = 1'b0;
		dlst_waddr    = count_q[IDX_W-1:0];
		dlst_wdata    = ent_q;
		smap_raddr    = ent_q;
		dlst_raddr    = idx_t'(count_q - cnt_t'(1));
		unique case (state_q)
			ST_CLEAR: begin
				smap_we    = 1'b1;
				smap_waddr = clr_q;
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				smap_raddr    = s_axis_tdata[IDX_W-1:0];
			end
			ST_READ: begin
				if (commit && do_add) begin
					smap_we    = 1'b1;
					smap_wdata = count_q;
					dlst_we    = 1'b1;
				end else if (commit && do_rem) begin
					// move the last id into the freed slot
					smap_we    = 1'b1;
					smap_waddr = back;
					smap_wdata = cur;
					dlst_we    = 1'b1;
					dlst_waddr = cur[IDX_W-1:0];
					dlst_wdata = back;
				end
			end
			ST_UNLINK: begin
				smap_we = 1'b1;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	// sequencer and count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + idx_t'(1);
			end
			if (commit) begin
				count_q <= res_cnt;
			end
		end
	end

	// capture the accepted word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= s_axis_tuser;
			ent_q <= s_axis_tdata[IDX_W-1:0];
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (commit) begin
			out_was_q  <= tracked;
			out_slot_q <= res_slot;
			out_cnt_q  <= res_cnt;
			out_err_q  <= is_track && tracked;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_err_q, out_cnt_q, out_slot_q, out_was_q};

	sset_ram #(
		.WIDTH (CNT_W),
		.DEPTH (MAX_IDS)
	) u_smap (
		.clk   (clk),
		.we    (smap_we),
		.waddr (smap_waddr),
		.wdata (smap_wdata),
		.raddr (smap_raddr),
		.rdata (smap_rdata)
	);

	sset_ram #(
		.WIDTH (IDX_W),
		.DEPTH (MAX_IDS)
	) u_dlst (
		.clk   (clk),
		.we    (dlst_we),
		.waddr (dlst_waddr),
		.wdata (dlst_wdata),
		.raddr (dlst_raddr),
		.rdata (dlst_rdata)
	);

endmodule

// ===== hdl/sset_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sset_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/sset_chk.sv =====
// Port-level checks for the sparse-set membership table, bound to the top.
// Depends on sset_pkg and sparse_set_membership_table.
module sset_chk
	import sset_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result word dropped while stalled");

	// one command in flight: no accept right after an accept
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second word accepted while busy");

	// count never passes the table depth
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[22:12] <= cnt_t'(MAX_IDS))
		else $error("count above table depth");

	// an error only comes with an id that was tracked
	a_err_trk: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[23] |-> m_axis_tdata[0])
		else $error("error flagged for untracked id");

	// a tracked id reports a valid slot below the count, except after untrack
	a_slot_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[11:1] != INVALID_SLOT)
			|-> m_axis_tdata[11:1] < m_axis_tdata[22:12])
		else $error("slot not below count");

endmodule

bind sparse_set_membership_table sset_chk u_sset_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
